// ----- rtl/fra_pkg.sv -----
// ----------------------------------------------------------------------------
// fra_pkg: shared types and constants of the fragment reassembly tracker
// Record layout, verdict and reason codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package fra_pkg;

  typedef enum logic [2:0] {
    VERDICT_PASS   = 3'd0,
    VERDICT_FIRST  = 3'd1,
    VERDICT_DUP    = 3'd2,
    VERDICT_APPEND = 3'd3,
    VERDICT_DONE   = 3'd4,
    VERDICT_OOS    = 3'd5
  } verdict_t;

  typedef enum logic [2:0] {
    REASON_NONE    = 3'd0,
    REASON_NOFIRST = 3'd1,
    REASON_SEQ     = 3'd2,
    REASON_TYPE    = 3'd3,
    REASON_DEST    = 3'd4,
    REASON_OTHER   = 3'd5
  } reason_t;

  // Reassembly record, apart from its busy mark which lives in flip-flops.
  typedef struct packed {
    logic [15:0] seq;
    logic [7:0]  typ;
    logic [7:0]  dest;
    logic [7:0]  max_flag;
    logic [7:0]  last_flag;
  } rec_t;

  // Update of one record together with the result of the beat.
  typedef struct packed {
    logic     rec_we;
    rec_t     rec;
    logic     busy_we;
    logic     busy_val;
    verdict_t verdict;
    reason_t  reason;
    logic     held_discarded;
  } upd_t;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OLD_IP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OLD_ARP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAGNOSE = 2'd2;

  localparam logic [7:0] OLD_IP_RESET   = 8'd240;
  localparam logic [7:0] OLD_ARP_RESET  = 8'd241;
  localparam logic [7:0] DIAGNOSE_RESET = 8'd128;

  localparam logic [7:0] FLAG_EXCEPTION = 8'hFF;
  localparam logic [7:0] FLAG_NONE      = 8'h00;
  localparam logic [8:0] FLAG_STEP      = 9'd2;

endpackage

`default_nettype wire

// ----- rtl/fra_store.sv -----
// ----------------------------------------------------------------------------
// fra_store: per-source reassembly records
// Record fields in a memory with a registered read port and write-to-read
// forwarding; busy marks in flip-flops cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_store #(
  parameter int NUM_SOURCES = 256,
  parameter int IDX_W       = 8
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              rd_en,
  input  wire  [IDX_W-1:0] rd_idx,
  output fra_pkg::rec_t    rd_rec,
  input  wire  [IDX_W-1:0] chk_idx,
  output logic             chk_busy,
  input  fra_pkg::upd_t    upd,
  input  wire              upd_valid
);
  import fra_pkg::*;

  rec_t                   mem [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] busy_bits;
  logic                   wr_en;

  assign wr_en    = upd_valid && upd.rec_we;
  assign chk_busy = busy_bits[chk_idx];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[chk_idx] <= upd.rec;
    end
  end

  // A beat read in the same cycle as the write to its own record sees the new data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (chk_idx == rd_idx)) begin
        rd_rec <= upd.rec;
      end else begin
        rd_rec <= mem[rd_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_bits <= '0;
    end else if (upd_valid && upd.busy_we) begin
      busy_bits[chk_idx] <= upd.busy_val;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fra_decide.sv -----
// ----------------------------------------------------------------------------
// fra_decide: fragment header decision
// Classifies one header against its source's record and forms the update.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_decide (
  input  wire  [7:0]     dst_host,
  input  wire  [7:0]     frame_type,
  input  wire  [7:0]     flag,
  input  wire  [15:0]    seq,
  input  wire            held,
  input  fra_pkg::rec_t  rec,
  input  wire  [7:0]     old_ip_type,
  input  wire  [7:0]     old_arp_type,
  input  wire  [7:0]     diagnose_type,
  output fra_pkg::upd_t  upd
);
  import fra_pkg::*;

  logic whole_type;
  logic next_flag;

  assign whole_type = (frame_type == old_ip_type) || (frame_type == old_arp_type) ||
                      (frame_type == diagnose_type);
  // Compared at nine bits, so a last flag near the top never wraps into a match.
  assign next_flag  = ({1'b0, flag} == ({1'b0, rec.last_flag} + FLAG_STEP));

  always_comb begin
    upd                = '0;
    upd.rec            = rec;
    upd.verdict        = VERDICT_PASS;
    upd.reason         = REASON_NONE;
    if (whole_type) begin
      upd.verdict = VERDICT_PASS;
    end else if (flag[0]) begin
      upd.rec_we         = 1'b1;
      upd.rec.seq        = seq;
      upd.rec.typ        = frame_type;
      upd.rec.dest       = dst_host;
      upd.rec.max_flag   = flag;
      upd.rec.last_flag  = FLAG_NONE;
      upd.busy_we        = 1'b1;
      upd.busy_val       = 1'b1;
      upd.verdict        = VERDICT_FIRST;
      upd.held_discarded = held;
    end else if (flag == FLAG_NONE) begin
      upd.verdict = VERDICT_PASS;
    end else if (!held) begin
      upd.verdict = VERDICT_OOS;
      upd.reason  = REASON_NOFIRST;
    end else if (seq != rec.seq) begin
      upd.verdict = VERDICT_OOS;
      upd.reason  = REASON_SEQ;
    end else if (frame_type != rec.typ) begin
      upd.verdict = VERDICT_OOS;
      upd.reason  = REASON_TYPE;
    end else if (dst_host != rec.dest) begin
      upd.verdict = VERDICT_OOS;
      upd.reason  = REASON_DEST;
    end else if (flag == rec.last_flag) begin
      upd.verdict = VERDICT_DUP;
    end else if (next_flag) begin
      upd.rec_we        = 1'b1;
      upd.rec.last_flag = flag;
      if (flag > rec.max_flag) begin
        upd.busy_we  = 1'b1;
        upd.busy_val = 1'b0;
        upd.verdict  = VERDICT_DONE;
      end else begin
        upd.verdict = VERDICT_APPEND;
      end
    end else begin
      upd.verdict = VERDICT_OOS;
      upd.reason  = REASON_OTHER;
    end
    // Any out-of-sequence beat with a record held throws that record away.
    if ((upd.verdict == VERDICT_OOS) && (upd.reason != REASON_NOFIRST)) begin
      upd.busy_we        = 1'b1;
      upd.busy_val       = 1'b0;
      upd.held_discarded = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fragment_reassembly_tracker.sv -----
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker: split-header reassembly bookkeeping
// Results: a taken header is registered into the s1 stage, and its result is
// registered from there into done, verdict, reason and held_discarded.
// Throughput: one header per cycle when not busy; the record read-modify-write sets it.
// busy is set during rst and cleared after it; reset clears the record busy marks only.
// The receiver cannot stall: done pulses for one cycle per result; the rest hold.
// ----------------------------------------------------------------------------
`default_nettype none

module fragment_reassembly_tracker #(
  parameter int NUM_SOURCES = 256
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  output logic                           busy,
  input  wire  [7:0]                     src_host,
  input  wire  [7:0]                     dst_host,
  input  wire  [7:0]                     frame_type,
  input  wire  [7:0]                     split_flag,
  input  wire  [15:0]                    seq_id,
  input  wire  [7:0]                     exc_split_flag,
  input  wire  [15:0]                    exc_seq_id,
  input  wire                            cfg_we,
  input  wire  [fra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [7:0]                     cfg_data,
  output logic                           done,
  output logic [2:0]                     verdict,
  output logic [2:0]                     reason,
  output logic                           held_discarded
);
  import fra_pkg::*;

  localparam int IDX_W = (NUM_SOURCES > 2) ? $clog2(NUM_SOURCES) : 1;

  typedef logic [IDX_W-1:0] idx_tab_t [256];

  // Source address to record index, worked out at elaboration.
  function automatic idx_tab_t build_idx_tab();
    idx_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = IDX_W'(i % NUM_SOURCES);
    end
    return tab;
  endfunction

  localparam idx_tab_t IDX_TAB = build_idx_tab();

  logic [7:0]       old_ip_type;
  logic [7:0]       old_arp_type;
  logic [7:0]       diagnose_type;
  logic             accept;
  logic             s1_valid;
  logic [IDX_W-1:0] s1_idx;
  logic [7:0]       s1_dst;
  logic [7:0]       s1_typ;
  logic [7:0]       s1_flag;
  logic [15:0]      s1_seq;
  logic [IDX_W-1:0] in_idx;
  rec_t             rd_rec;
  logic             s1_held;
  upd_t             upd;

  assign accept = start && !busy;
  assign in_idx = IDX_TAB[src_host];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      old_ip_type   <= OLD_IP_RESET;
      old_arp_type  <= OLD_ARP_RESET;
      diagnose_type <= DIAGNOSE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OLD_IP:   old_ip_type   <= cfg_data;
        CFG_OLD_ARP:  old_arp_type  <= cfg_data;
        CFG_DIAGNOSE: diagnose_type <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  // An exception header carries its flag and sequence id in the second header.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx <= in_idx;
      s1_dst <= dst_host;
      s1_typ <= frame_type;
      if (split_flag == FLAG_EXCEPTION) begin
        s1_flag <= exc_split_flag;
        s1_seq  <= exc_seq_id;
      end else begin
        s1_flag <= split_flag;
        s1_seq  <= seq_id;
      end
    end
  end

  fra_store #(
    .NUM_SOURCES (NUM_SOURCES),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_idx    (in_idx),
    .rd_rec    (rd_rec),
    .chk_idx   (s1_idx),
    .chk_busy  (s1_held),
    .upd       (upd),
    .upd_valid (s1_valid)
  );

  fra_decide u_decide (
    .dst_host      (s1_dst),
    .frame_type    (s1_typ),
    .flag          (s1_flag),
    .seq           (s1_seq),
    .held          (s1_held),
    .rec           (rd_rec),
    .old_ip_type   (old_ip_type),
    .old_arp_type  (old_arp_type),
    .diagnose_type (diagnose_type),
    .upd           (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      verdict        <= upd.verdict;
      reason         <= upd.reason;
      held_discarded <= upd.held_discarded;
    end
  end

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the fragment reassembly tracker
// A short table of hand-picked headers is followed by random traffic, most of
// it well-formed fragment trains on a few stations with duplicates, broken
// fields and noise mixed in. Every beat is checked against a given result or a
// local model of the per-station reassembly records under several register settings.
// ----------------------------------------------------------------------------
module tb;
  import fra_pkg::*;

  localparam int NUM_SRC = 256;
  localparam int SENDS_PER_PHASE = 285;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 100;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam bit TYPED = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef struct packed {
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [7:0]  typ;
    logic [7:0]  flag;
    logic [15:0] seq;
    logic [7:0]  xflag;
    logic [15:0] xseq;
  } frag_hdr_t;

  typedef struct packed {
    verdict_t verdict;
    reason_t  reason;
    logic     held;
  } frag_res_t;

  typedef struct packed {
    frag_hdr_t hdr;
    logic      typed;
    frag_res_t want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [7:0]           src_host = '0;
  logic [7:0]           dst_host = '0;
  logic [7:0]           frame_type = '0;
  logic [7:0]           split_flag = '0;
  logic [15:0]          seq_id = '0;
  logic [7:0]           exc_split_flag = '0;
  logic [15:0]          exc_seq_id = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;
  logic                 busy;
  logic                 done;
  logic [2:0]           verdict;
  logic [2:0]           reason;
  logic                 held_discarded;

  // Local copy of the registers and of the reassembly records.
  logic [7:0]  old_ip_cfg = OLD_IP_RESET;
  logic [7:0]  old_arp_cfg = OLD_ARP_RESET;
  logic [7:0]  diagnose_cfg = DIAGNOSE_RESET;
  logic        rec_busy [NUM_SRC];
  logic [15:0] rec_seq [NUM_SRC];
  logic [7:0]  rec_type [NUM_SRC];
  logic [7:0]  rec_dest [NUM_SRC];
  logic [7:0]  rec_max [NUM_SRC];
  logic [7:0]  rec_last [NUM_SRC];

  frag_res_t   pending_verdicts [$];
  stim_row_t   directed_rows [$];
  logic [7:0]  src_pool [8];
  int unsigned mismatches = 0;
  int unsigned tracked_items = 0;
  int unsigned idle_pct = 30;
  int unsigned idle_cycles = 0;

  fragment_reassembly_tracker #(
    .NUM_SOURCES(NUM_SRC)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .src_host(src_host),
    .dst_host(dst_host),
    .frame_type(frame_type),
    .split_flag(split_flag),
    .seq_id(seq_id),
    .exc_split_flag(exc_split_flag),
    .exc_seq_id(exc_seq_id),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .verdict(verdict),
    .reason(reason),
    .held_discarded(held_discarded)
  );

  always #5 clk = ~clk;

  function automatic bit is_whole_type(input logic [7:0] t);
    return t == old_ip_cfg || t == old_arp_cfg || t == diagnose_cfg;
  endfunction

  // Works out the verdict of one header and updates the record it selects.
  function automatic frag_res_t track_fragment(input frag_hdr_t h);
    frag_res_t   res;
    logic [7:0]  flag;
    logic [15:0] seq;
    int unsigned idx;
    reason_t     why;
    res.verdict = VERDICT_PASS;
    res.reason = REASON_NONE;
    res.held = 1'b0;
    if (is_whole_type(h.typ)) return res;
    flag = h.flag;
    seq = h.seq;
    if (h.flag == FLAG_EXCEPTION) begin
      flag = h.xflag;
      seq = h.xseq;
    end
    idx = h.src % NUM_SRC;
    if (flag[0]) begin
      res.verdict = VERDICT_FIRST;
      res.held = rec_busy[idx];
      rec_busy[idx] = 1'b1;
      rec_seq[idx] = seq;
      rec_type[idx] = h.typ;
      rec_dest[idx] = h.dst;
      rec_max[idx] = flag;
      rec_last[idx] = FLAG_NONE;
      return res;
    end
    if (flag == FLAG_NONE) return res;
    if (!rec_busy[idx]) begin
      res.verdict = VERDICT_OOS;
      res.reason = REASON_NOFIRST;
      return res;
    end
    if (seq != rec_seq[idx]) begin
      why = REASON_SEQ;
    end else if (h.typ != rec_type[idx]) begin
      why = REASON_TYPE;
    end else if (h.dst != rec_dest[idx]) begin
      why = REASON_DEST;
    end else if (flag == rec_last[idx]) begin
      res.verdict = VERDICT_DUP;
      return res;
    end else if ({1'b0, flag} == {1'b0, rec_last[idx]} + FLAG_STEP) begin
      // The sum is taken at nine bits, so a last flag of 254 never advances.
      rec_last[idx] = flag;
      if (flag > rec_max[idx]) begin
        rec_busy[idx] = 1'b0;
        res.verdict = VERDICT_DONE;
      end else begin
        res.verdict = VERDICT_APPEND;
      end
      return res;
    end else begin
      why = REASON_OTHER;
    end
    rec_busy[idx] = 1'b0;
    res.verdict = VERDICT_OOS;
    res.reason = why;
    res.held = 1'b1;
    return res;
  endfunction

  function automatic frag_hdr_t mk_hdr(input int unsigned src, dst, typ, flag, seq,
                                       xflag, xseq);
    frag_hdr_t h;
    h.src = 8'(src);
    h.dst = 8'(dst);
    h.typ = 8'(typ);
    h.flag = 8'(flag);
    h.seq = 16'(seq);
    h.xflag = 8'(xflag);
    h.xseq = 16'(xseq);
    return h;
  endfunction

  // Mostly the next fragment of a train in progress, or the first of a new one.
  function automatic frag_hdr_t random_header();
    frag_hdr_t   h;
    logic [7:0]  f;
    logic [15:0] sq;
    int unsigned idx;
    int unsigned roll;
    roll = $urandom_range(99);
    h.src = src_pool[$urandom_range(7)];
    h.dst = 8'($urandom);
    h.typ = 8'($urandom);
    h.flag = 8'($urandom);
    h.seq = 16'($urandom);
    h.xflag = 8'($urandom);
    h.xseq = 16'($urandom);
    if (roll < 15) begin
      if (roll < 5) h.src = 8'($urandom);
      return h;
    end
    idx = h.src % NUM_SRC;
    sq = 16'($urandom);
    if (!rec_busy[idx] || rec_last[idx] >= 8'd254) begin
      f = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(15));
      f[0] = 1'b1;
    end else begin
      h.dst = rec_dest[idx];
      h.typ = rec_type[idx];
      sq = rec_seq[idx];
      f = rec_last[idx] + 8'd2;
      if (roll < 25) begin
        f = rec_last[idx];
      end else if (roll < 35) begin
        case ($urandom_range(3))
          0: sq ^= 16'($urandom_range(1, 16'hFFFF));
          1: h.typ ^= 8'($urandom_range(1, 8'hFF));
          2: h.dst ^= 8'($urandom_range(1, 8'hFF));
          default: f = f + 8'(2 * $urandom_range(1, 3));
        endcase
      end
    end
    if (f == FLAG_EXCEPTION || $urandom_range(3) == 0) begin
      h.flag = FLAG_EXCEPTION;
      h.xflag = f;
      h.xseq = sq;
    end else begin
      h.flag = f;
      h.seq = sq;
    end
    return h;
  endfunction

  // Called just after a rising edge; returns just after the edge that takes the beat.
  task automatic send_header(input frag_hdr_t h, input bit typed = PREDICTED,
                             input frag_res_t want = '0);
    frag_res_t got;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    src_host <= h.src;
    dst_host <= h.dst;
    frame_type <= h.typ;
    split_flag <= h.flag;
    seq_id <= h.seq;
    exc_split_flag <= h.xflag;
    exc_seq_id <= h.xseq;
    do @(posedge clk); while (busy !== 1'b0);
    got = track_fragment(h);
    pending_verdicts.push_back(typed ? want : got);
    if (got.verdict != VERDICT_PASS) tracked_items++;
  endtask

  task automatic add_row(input frag_hdr_t h, input bit typed,
                         input verdict_t v = VERDICT_PASS,
                         input reason_t r = REASON_NONE, input logic held = 1'b0);
    stim_row_t row;
    row.hdr = h;
    row.typed = typed;
    row.want.verdict = v;
    row.want.reason = r;
    row.want.held = held;
    directed_rows.push_back(row);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] ip, arp, diag);
    cfg_we <= 1'b1;
    cfg_index <= CFG_OLD_IP;
    cfg_data <= ip;
    @(posedge clk);
    cfg_index <= CFG_OLD_ARP;
    cfg_data <= arp;
    @(posedge clk);
    cfg_index <= CFG_DIAGNOSE;
    cfg_data <= diag;
    @(posedge clk);
    // A write beyond the register list must change nothing.
    cfg_index <= CFG_UNUSED;
    cfg_data <= 8'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    old_ip_cfg = ip;
    old_arp_cfg = arp;
    diagnose_cfg = diag;
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned mark;
    foreach (src_pool[i]) src_pool[i] = 8'($urandom);
    mark = tracked_items;
    while (tracked_items - mark < n) send_header(random_header());
  endtask

  task automatic report(input string what, input int unsigned want, input logic [2:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : result_check
    frag_res_t want;
    if (!rst && done === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result with no header outstanding: verdict %0d, reason %0d",
                   $time, verdict, reason);
      end else begin
        want = pending_verdicts.pop_front();
        if (verdict !== want.verdict) report("verdict", want.verdict, verdict);
        if (reason !== want.reason) report("reason", want.reason, reason);
        if (held_discarded !== want.held)
          report("held_discarded", want.held, {2'b00, held_discarded});
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned s, d, t, q;
    for (int i = 0; i < NUM_SRC; i++) begin
      rec_busy[i] = 1'b0;
      rec_seq[i] = '0;
      rec_type[i] = '0;
      rec_dest[i] = '0;
      rec_max[i] = '0;
      rec_last[i] = '0;
    end

    // Reset register values; records all empty.
    add_row(mk_hdr(0, 0, 'h01, 2, 0, 0, 0), TYPED, VERDICT_OOS, REASON_NOFIRST, 1'b0);
    add_row(mk_hdr(3, 1, OLD_IP_RESET, 3, 0, 0, 0), TYPED, VERDICT_PASS);
    add_row(mk_hdr(3, 1, OLD_ARP_RESET, FLAG_EXCEPTION, 0, 1, 0), TYPED, VERDICT_PASS);
    add_row(mk_hdr(3, 1, DIAGNOSE_RESET, 1, 0, 0, 0), TYPED, VERDICT_PASS);
    add_row(mk_hdr(3, 1, 'h01, FLAG_NONE, 0, 0, 0), TYPED, VERDICT_PASS);
    add_row(mk_hdr(255, 255, 255, 1, 'hFFFF, 0, 0), TYPED, VERDICT_FIRST);
    add_row(mk_hdr(255, 255, 255, 2, 'hFFFF, 0, 0), TYPED, VERDICT_DONE);
    add_row(mk_hdr(0, 0, 0, FLAG_EXCEPTION, 'h1111, FLAG_NONE, 0), TYPED, VERDICT_PASS);
    // A full train with a duplicate in the middle.
    add_row(mk_hdr(5, 7, 'h20, 5, 'h1234, 0, 0), PREDICTED);
    add_row(mk_hdr(5, 7, 'h20, 2, 'h1234, 0, 0), PREDICTED);
    add_row(mk_hdr(5, 7, 'h20, 2, 'h1234, 0, 0), PREDICTED);
    add_row(mk_hdr(5, 7, 'h20, 4, 'h1234, 0, 0), PREDICTED);
    add_row(mk_hdr(5, 7, 'h20, 6, 'h1234, 0, 0), PREDICTED);
    // Restart over a held train, then each way a train can be broken.
    add_row(mk_hdr(5, 7, 'h20, 3, 'h1234, 0, 0), PREDICTED);
    add_row(mk_hdr(5, 7, 'h20, 3, 'h5678, 0, 0), TYPED, VERDICT_FIRST, REASON_NONE, 1'b1);
    add_row(mk_hdr(5, 7, 'h20, 2, 'h1234, 0, 0), TYPED, VERDICT_OOS, REASON_SEQ, 1'b1);
    add_row(mk_hdr(5, 7, 'h20, 1, 'h1234, 0, 0), PREDICTED);
    add_row(mk_hdr(5, 7, 'h21, 2, 'h1234, 0, 0), TYPED, VERDICT_OOS, REASON_TYPE, 1'b1);
    add_row(mk_hdr(5, 7, 'h20, 1, 'h1234, 0, 0), PREDICTED);
    add_row(mk_hdr(5, 8, 'h20, 2, 'h1234, 0, 0), TYPED, VERDICT_OOS, REASON_DEST, 1'b1);
    add_row(mk_hdr(5, 7, 'h20, 1, 'h1234, 0, 0), PREDICTED);
    add_row(mk_hdr(5, 7, 'h20, 4, 'h1234, 0, 0), TYPED, VERDICT_OOS, REASON_OTHER, 1'b1);
    // Exception headers take flag and sequence id from the second header.
    add_row(mk_hdr(9, 'hAA, 'h55, FLAG_EXCEPTION, 0, 7, 'hABCD), PREDICTED);
    add_row(mk_hdr(9, 'hAA, 'h55, FLAG_EXCEPTION, 'hFFFF, 2, 'hABCD), PREDICTED);
    add_row(mk_hdr(9, 'hAA, 'h55, 4, 'hABCD, FLAG_EXCEPTION, 'hFFFF), PREDICTED);
    add_row(mk_hdr(9, 'h55, 'hAA, FLAG_EXCEPTION, 0, FLAG_EXCEPTION, 'h5555), PREDICTED);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_header(directed_rows[i].hdr, directed_rows[i].typed, directed_rows[i].want);
    run_random(SENDS_PER_PHASE);
    drain();

    // Long stretch with the sender never idling.
    idle_pct = 0;
    set_config(8'd0, 8'd0, 8'd0);
    run_random(SENDS_PER_PHASE);
    drain();

    idle_pct = 30;
    set_config(8'd255, 8'd255, 8'd255);
    // One train that runs to the top flag, where the next flag cannot follow.
    s = $urandom_range(255);
    d = $urandom_range(255);
    q = $urandom_range(16'hFFFF);
    do t = $urandom_range(255); while (is_whole_type(8'(t)));
    send_header(mk_hdr(s, d, t, FLAG_EXCEPTION, $urandom, FLAG_EXCEPTION, q));
    for (int f = 2; f <= 254; f += 2) send_header(mk_hdr(s, d, t, f, q, $urandom, $urandom));
    send_header(mk_hdr(s, d, t, 254, q, $urandom, $urandom));
    send_header(mk_hdr(s, d, t, 2, q, $urandom, $urandom));
    run_random(SENDS_PER_PHASE);
    drain();

    set_config(8'($urandom), 8'($urandom), 8'($urandom));
    run_random(SENDS_PER_PHASE);
    drain();

    set_config(8'd1, 8'd254, DIAGNOSE_RESET);
    run_random(SENDS_PER_PHASE);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
